>>> design/lzwc_pkg.sv
// Shared types, constants and the slot hash for the LZW compressor.
// No dependencies.
package lzwc_pkg;

  localparam int MAX_CODE_BITS = 12;
  localparam int CODE_W        = MAX_CODE_BITS;
  localparam int DICT_DEPTH    = 1 << MAX_CODE_BITS;
  localparam int HASH_W        = MAX_CODE_BITS + 1;
  localparam int HASH_DEPTH    = 1 << HASH_W;
  localparam int KEY_W         = CODE_W + 8;
  localparam int DENT_W        = HASH_W + KEY_W;
  localparam int NFC_W         = CODE_W + 1;

  localparam logic [CODE_W-1:0] END_CODE   = CODE_W'(256);
  localparam logic [CODE_W-1:0] FIRST_FREE = CODE_W'(257);
  localparam logic [3:0]        MIN_BITS   = 4'd9;
  localparam logic [3:0]        TOP_BITS   = 4'(MAX_CODE_BITS);

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_stream;
  } in_t;

  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic              last;
  } out_t;

  function automatic logic [HASH_W-1:0] slot_hash(input logic [CODE_W-1:0] prefix,
                                                   input logic [7:0] b);
    logic [HASH_W-1:0] hb;
    hb = HASH_W'({b, 5'b0});
    return hb ^ HASH_W'(prefix);
  endfunction

endpackage

>>> design/lzw_compressor.sv
// LZW compressor top: input queue, search engine, result queue.
// Each byte after the first of a stream runs one hash probe (slot read, dictionary read,
// compare), and one more probe per slot taken by another key; end of stream adds the
// last prefix and the end code. The engine takes a new byte only once done with the last.
// Reset: synchronous; then a pass clears the hash table, bytes queue meanwhile.
module lzw_compressor (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  output logic           full,
  input  lzwc_pkg::in_t  item,
  output logic           empty,
  output lzwc_pkg::out_t result,
  input  logic           pop,
  input  logic           cfg_we,
  input  logic [3:0]     cfg_data
);

  logic [3:0]     max_code_bits;
  logic           q_valid;
  lzwc_pkg::in_t  q_head;
  logic           q_take;
  logic           o_room;
  logic           o_wr;
  logic           o_ovf;
  lzwc_pkg::out_t o_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_code_bits <= lzwc_pkg::TOP_BITS;
    end else if (cfg_we) begin
      max_code_bits <= cfg_data;
    end
  end

  lzwc_front u_front (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .full  (full),
    .item  (item),
    .valid (q_valid),
    .head  (q_head),
    .take  (q_take)
  );

  lzwc_engine u_engine (
    .clk           (clk),
    .rst           (rst),
    .max_code_bits (max_code_bits),
    .in_valid      (q_valid),
    .in_item       (q_head),
    .in_take       (q_take),
    .out_room      (o_room),
    .out_wr        (o_wr),
    .out_data      (o_data)
  );

  lzwc_outq u_outq (
    .clk    (clk),
    .rst    (rst),
    .wr     (o_wr),
    .wdata  (o_data),
    .room   (o_room),
    .ovf    (o_ovf),
    .empty  (empty),
    .result (result),
    .pop    (pop)
  );

  a_no_ovf: assert property (@(posedge clk) disable iff (rst) !o_ovf)
    else $error("result queue overflow");

  a_last_end: assert property (@(posedge clk) disable iff (rst)
    (!empty && result.last) |-> (result.code == lzwc_pkg::END_CODE))
    else $error("last beat without end code");

  a_rst_empty: assert property (@(posedge clk) rst |=> (empty && !o_wr))
    else $error("results present after reset");

endmodule

>>> design/lzwc_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module lzwc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> design/lzwc_front.sv
// Input side: two-entry queue of incoming byte beats.
// Depends on lzwc_pkg.
module lzwc_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  output logic          full,
  input  lzwc_pkg::in_t item,
  output logic          valid,
  output lzwc_pkg::in_t head,
  input  logic          take
);

  lzwc_pkg::in_t slots [2];
  logic       wptr;
  logic       rptr;
  logic [1:0] count;

  logic do_push;
  logic do_take;

  assign full    = (count == 2'd2);
  assign valid   = (count != 2'd0);
  assign head    = slots[rptr];
  assign do_push = push && !full;
  assign do_take = take && valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wptr] <= item;
    end
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (do_push) wptr <= !wptr;
      if (do_take) rptr <= !rptr;
      count <= count + 2'(do_push) - 2'(do_take);
    end
  end

endmodule

>>> design/lzwc_outq.sv
// Result queue: four entries, one push and one pop a cycle.
// Depends on lzwc_pkg.
module lzwc_outq (
  input  logic           clk,
  input  logic           rst,
  input  logic           wr,
  input  lzwc_pkg::out_t wdata,
  output logic           room,
  output logic           ovf,
  output logic           empty,
  output lzwc_pkg::out_t result,
  input  logic           pop
);

  lzwc_pkg::out_t slots [4];
  logic [1:0] wptr;
  logic [1:0] rptr;
  logic [2:0] count;

  logic do_pop;

  assign empty  = (count == 3'd0);
  assign result = slots[rptr];
  assign room   = (count <= 3'd1);
  assign ovf    = wr && (count == 3'd4);
  assign do_pop = pop && !empty;

  always_ff @(posedge clk) begin
    if (wr) begin
      slots[wptr] <= wdata;
    end
    if (rst) begin
      wptr  <= 2'd0;
      rptr  <= 2'd0;
      count <= 3'd0;
    end else begin
      if (wr)     wptr <= wptr + 2'd1;
      if (do_pop) rptr <= rptr + 2'd1;
      count <= count + 3'(wr) - 3'(do_pop);
    end
  end

endmodule

>>> design/lzwc_engine.sv
// Back end: hashed dictionary search, entry insert and code emission.
// Depends on lzwc_pkg and lzwc_ram.
module lzwc_engine (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [3:0]                    max_code_bits,
  input  logic                          in_valid,
  input  lzwc_pkg::in_t                 in_item,
  output logic                          in_take,
  input  logic                          out_room,
  output logic                          out_wr,
  output lzwc_pkg::out_t                out_data
);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_SLOT  = 3'd2;
  localparam logic [2:0] S_CMP   = 3'd3;
  localparam logic [2:0] S_EOS1  = 3'd4;
  localparam logic [2:0] S_EOS2  = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;

  logic [lzwc_pkg::HASH_W-1:0] clr_addr;
  logic [lzwc_pkg::HASH_W-1:0] probe;
  logic [lzwc_pkg::CODE_W-1:0] prefix;
  logic                        prefix_valid;
  logic [lzwc_pkg::NFC_W-1:0]  next_free;
  logic [lzwc_pkg::CODE_W-1:0] slot_code;
  logic [7:0]                  cur_byte;
  logic                        cur_eos;

  logic                        h_we;
  logic [lzwc_pkg::HASH_W-1:0] h_waddr;
  logic [lzwc_pkg::CODE_W-1:0] h_wdata;
  logic [lzwc_pkg::HASH_W-1:0] h_raddr;
  logic [lzwc_pkg::CODE_W-1:0] h_rdata;
  logic                        d_we;
  logic [lzwc_pkg::DENT_W-1:0] d_rdata;

  logic [3:0]                  bits;
  logic [lzwc_pkg::NFC_W-1:0]  limit;
  logic                        occupied;
  logic                        hit;
  logic                        can_add;
  logic [lzwc_pkg::KEY_W-1:0]  key;
  logic [lzwc_pkg::HASH_W-1:0] h_new;

  always_comb begin
    bits = max_code_bits;
    if (bits < lzwc_pkg::MIN_BITS) bits = lzwc_pkg::MIN_BITS;
    if (bits > lzwc_pkg::TOP_BITS) bits = lzwc_pkg::TOP_BITS;
  end

  // a slot is live only if its entry was inserted at this very slot in this stream
  assign limit    = lzwc_pkg::NFC_W'(1) << bits;
  assign key      = {prefix, cur_byte};
  assign h_new    = lzwc_pkg::slot_hash(prefix, in_item.data_byte);
  assign occupied = (slot_code >= lzwc_pkg::FIRST_FREE) &&
                    (lzwc_pkg::NFC_W'(slot_code) < next_free) &&
                    (d_rdata[lzwc_pkg::DENT_W-1:lzwc_pkg::KEY_W] == probe);
  assign hit      = occupied && (d_rdata[lzwc_pkg::KEY_W-1:0] == key);
  assign can_add  = next_free < limit;
  assign in_take  = (state == S_IDLE) && in_valid && out_room;

  always_comb begin
    h_raddr = probe;
    if (state == S_IDLE) h_raddr = h_new;
    if (state == S_CMP)  h_raddr = probe + lzwc_pkg::HASH_W'(1);
  end

  always_comb begin
    h_we    = 1'b0;
    h_waddr = probe;
    h_wdata = next_free[lzwc_pkg::CODE_W-1:0];
    d_we    = 1'b0;
    if (state == S_CLEAR) begin
      h_we    = 1'b1;
      h_waddr = clr_addr;
      h_wdata = '0;
    end else if (state == S_CMP && !occupied && can_add) begin
      h_we = 1'b1;
      d_we = 1'b1;
    end
  end

  always_comb begin
    out_wr   = 1'b0;
    out_data = '{code: prefix, last: 1'b0};
    case (state)
      S_CMP:   out_wr = !hit && !occupied;
      S_EOS1:  out_wr = 1'b1;
      S_EOS2: begin
        out_wr   = 1'b1;
        out_data = '{code: lzwc_pkg::END_CODE, last: 1'b1};
      end
      default: out_wr = 1'b0;
    endcase
  end

  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR: if (&clr_addr) state_next = S_IDLE;
      S_IDLE: begin
        if (in_take) begin
          if (!prefix_valid) begin
            state_next = in_item.end_of_stream ? S_EOS1 : S_IDLE;
          end else begin
            state_next = S_SLOT;
          end
        end
      end
      S_SLOT:  state_next = S_CMP;
      S_CMP: begin
        if (occupied && !hit) state_next = S_SLOT;
        else                  state_next = cur_eos ? S_EOS1 : S_IDLE;
      end
      S_EOS1:  state_next = S_EOS2;
      S_EOS2:  state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (state == S_SLOT) slot_code <= h_rdata;
    if (in_take) begin
      cur_byte <= in_item.data_byte;
      cur_eos  <= in_item.end_of_stream;
      probe    <= h_new;
    end else if (state == S_CMP) begin
      probe <= probe + lzwc_pkg::HASH_W'(1);
    end
    if (rst) begin
      state        <= S_CLEAR;
      clr_addr     <= '0;
      prefix       <= '0;
      prefix_valid <= 1'b0;
      next_free    <= lzwc_pkg::NFC_W'(lzwc_pkg::FIRST_FREE);
    end else begin
      state <= state_next;
      if (state == S_CLEAR) clr_addr <= clr_addr + lzwc_pkg::HASH_W'(1);
      if (in_take && !prefix_valid) begin
        prefix       <= lzwc_pkg::CODE_W'(in_item.data_byte);
        prefix_valid <= 1'b1;
      end
      if (state == S_CMP) begin
        if (hit) begin
          prefix <= slot_code;
        end else if (!occupied) begin
          prefix <= lzwc_pkg::CODE_W'(cur_byte);
          if (can_add) next_free <= next_free + lzwc_pkg::NFC_W'(1);
        end
      end
      if (state == S_EOS2) begin
        prefix       <= '0;
        prefix_valid <= 1'b0;
        next_free    <= lzwc_pkg::NFC_W'(lzwc_pkg::FIRST_FREE);
      end
    end
  end

  lzwc_ram #(.WIDTH(lzwc_pkg::CODE_W), .DEPTH(lzwc_pkg::HASH_DEPTH)) u_hash (
    .clk   (clk),
    .we    (h_we),
    .waddr (h_waddr),
    .wdata (h_wdata),
    .raddr (h_raddr),
    .rdata (h_rdata)
  );

  lzwc_ram #(.WIDTH(lzwc_pkg::DENT_W), .DEPTH(lzwc_pkg::DICT_DEPTH)) u_dict (
    .clk   (clk),
    .we    (d_we),
    .waddr (next_free[lzwc_pkg::CODE_W-1:0]),
    .wdata ({probe, key}),
    .raddr (h_rdata),
    .rdata (d_rdata)
  );

endmodule

>>> tb/sv/lzw_compressor_tb.sv
// Self-checking testbench for lzw_compressor: byte streams go in through the
// push/full queue, codes are checked against an in-bench LZW predictor.
// Depends on lzwc_pkg and lzw_compressor.
`timescale 1ns / 100ps

module lzw_compressor_tb;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic push = 1'b0;
  logic full;
  lzwc_pkg::in_t item = '0;
  logic empty;
  lzwc_pkg::out_t result;
  logic pop = 1'b0;
  logic cfg_we = 1'b0;
  logic [3:0] cfg_data = 4'd0;

  lzw_compressor dut (
    .clk(clk), .rst(rst), .push(push), .full(full), .item(item),
    .empty(empty), .result(result), .pop(pop), .cfg_we(cfg_we), .cfg_data(cfg_data)
  );

  always #10 clk = ~clk;

  // predictor state
  logic [lzwc_pkg::KEY_W-1:0] dict_key [lzwc_pkg::DICT_DEPTH];
  int unsigned free_code;
  logic [lzwc_pkg::CODE_W-1:0] prefix;
  bit have_prefix;
  logic [3:0] width_reg;
  lzwc_pkg::out_t code_queue [$];

  int errors;
  int quiet_cycles;
  bit no_idle;
  int sent;

  function automatic int unsigned table_limit();
    int unsigned b;
    b = width_reg;
    if (b < lzwc_pkg::MIN_BITS) b = lzwc_pkg::MIN_BITS;
    if (b > lzwc_pkg::MAX_CODE_BITS) b = lzwc_pkg::MAX_CODE_BITS;
    return 1 << b;
  endfunction

  function automatic void expect_code(logic [lzwc_pkg::CODE_W-1:0] c, logic l);
    lzwc_pkg::out_t r;
    r.code = c;
    r.last = l;
    code_queue.insert(code_queue.size(), r);
  endfunction

  function automatic void predict_byte(lzwc_pkg::in_t it);
    int unsigned hit;
    hit = 0;
    if (!have_prefix) begin
      prefix = lzwc_pkg::CODE_W'(it.data_byte);
      have_prefix = 1'b1;
    end else begin
      for (int unsigned c = lzwc_pkg::FIRST_FREE;
           c < free_code && c < lzwc_pkg::DICT_DEPTH; c++)
        if (hit == 0 && dict_key[c] == {prefix, it.data_byte}) hit = c;
      if (hit != 0) begin
        prefix = lzwc_pkg::CODE_W'(hit);
      end else begin
        expect_code(prefix, 1'b0);
        if (free_code < table_limit() && free_code < lzwc_pkg::DICT_DEPTH) begin
          dict_key[free_code] = {prefix, it.data_byte};
          free_code++;
        end
        prefix = lzwc_pkg::CODE_W'(it.data_byte);
      end
    end
    if (it.end_of_stream) begin
      expect_code(prefix, 1'b0);
      expect_code(lzwc_pkg::END_CODE, 1'b1);
      have_prefix = 1'b0;
      prefix = '0;
      free_code = lzwc_pkg::FIRST_FREE;
    end
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic eos);
    while (!no_idle && $urandom_range(99) < 37) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    item <= '{data_byte: b, end_of_stream: eos};
    @(posedge clk);
    while (full) @(posedge clk);
    predict_byte('{data_byte: b, end_of_stream: eos});
    sent++;
  endtask

  task automatic wait_drained();
    push <= 1'b0;
    while (code_queue.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic set_width(input logic [3:0] w);
    wait_drained();
    cfg_we <= 1'b1;
    cfg_data <= w;
    @(posedge clk);
    cfg_we <= 1'b0;
    width_reg = w;
  endtask

  // result side
  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (code_queue.size() == 0) begin
          $error("unexpected beat: code %0d last %0b", result.code, result.last);
          errors++;
        end else begin
          lzwc_pkg::out_t e;
          e = code_queue.pop_front();
          if (result.code !== e.code) begin
            $error("code: expected %0d, got %0d", e.code, result.code);
            errors++;
          end
          if (result.last !== e.last) begin
            $error("last: expected %0b, got %0b", e.last, result.last);
            errors++;
          end
        end
      end
      pop <= no_idle ? 1'b1 : ($urandom_range(99) >= 37);
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > 50000) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic test_edges();
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b1);
    send_byte(8'hAA, 1'b0);
    send_byte(8'hAA, 1'b0);
    send_byte(8'hAA, 1'b0);
    send_byte(8'hAA, 1'b0);
    send_byte(8'h55, 1'b0);
    send_byte(8'hAA, 1'b0);
    send_byte(8'hAA, 1'b1);
    for (int i = 0; i < 8; i++) send_byte(8'(i * 37), i == 7);
  endtask

  task automatic test_full_table();
    // 9-bit table fills after 255 new entries; keep going past it
    set_width(4'd0);
    for (int i = 0; i < 256; i++) begin
      no_idle = (i >= 40 && i < 200);
      send_byte(8'(i), 1'b0);
    end
    no_idle = 1'b0;
    for (int i = 0; i < 4; i++) send_byte(8'(i * 2), 1'b0);
    set_width(4'd15);
    for (int i = 0; i < 4; i++) send_byte(8'(i), i == 3);
  endtask

  task automatic test_width_drop();
    set_width(4'd12);
    for (int i = 0; i < 16; i++) send_byte(8'($urandom_range(7)), 1'b0);
    set_width(4'd9);
    for (int i = 0; i < 8; i++) send_byte(8'($urandom_range(7)), i == 7);
  endtask

  task automatic test_random_streams();
    int len;
    int alpha;
    set_width(4'($urandom_range(9, 12)));
    while (sent < 320) begin
      len = $urandom_range(1, 12);
      alpha = ($urandom_range(3) == 0) ? 255 : $urandom_range(1, 7);
      for (int i = 0; i < len; i++)
        send_byte(8'($urandom_range(alpha)), i == len - 1 || $urandom_range(49) == 0);
    end
  endtask

  initial begin
    errors = 0;
    sent = 0;
    no_idle = 1'b0;
    free_code = lzwc_pkg::FIRST_FREE;
    prefix = '0;
    have_prefix = 1'b0;
    width_reg = 4'd12;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    test_edges();
    test_width_drop();
    test_full_table();
    test_random_streams();
    wait_drained();
    if (errors == 0 && code_queue.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule
